// ===== design/two_class_queue_burst_limited_arbiter_defines.svh =====
// Assertion helpers used by the arbiter RTL (tcqa_ctrl).
`ifndef TWO_CLASS_QUEUE_BURST_LIMITED_ARBITER_DEFINES_SVH
`define TWO_CLASS_QUEUE_BURST_LIMITED_ARBITER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define TCQA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define TCQA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TCQA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tcqa_pkg.sv =====
`timescale 1ns / 1ps
package tcqa_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BURST_W  = 4;

  localparam logic [CMD_W-1:0] CMD_ENQ_NORMAL   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENQ_PRIORITY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SERVE        = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ENQUEUED        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SERVED_NORMAL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SERVED_PRIORITY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WAIT            = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED         = 3'd4;

  localparam logic [BURST_W-1:0] BURST_LIMIT_RESET = 4'd3;

  // memory strobes and result code for one request
  typedef struct packed {
    logic                wr_normal;
    logic                wr_priority;
    logic                rd_normal;
    logic                rd_priority;
    logic [STATUS_W-1:0] status;
  } tcqa_req_t;

endpackage

// ===== design/tcqa_store.sv =====
`timescale 1ns / 1ps
module tcqa_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/tcqa_ctrl.sv =====
`timescale 1ns / 1ps
`include "two_class_queue_burst_limited_arbiter_defines.svh"
module tcqa_ctrl
  import tcqa_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned PTR_W      = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [CMD_W-1:0]   command,
  input  logic [BURST_W-1:0] burst_limit,
  output tcqa_req_t          req,
  output logic [PTR_W-1:0]   n_head,
  output logic [PTR_W-1:0]   n_tail,
  output logic [PTR_W-1:0]   p_head,
  output logic [PTR_W-1:0]   p_tail
);

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0]   n_head_r, n_head_nxt, n_tail_r, n_tail_nxt;
  logic [PTR_W-1:0]   p_head_r, p_head_nxt, p_tail_r, p_tail_nxt;
  logic [CNT_W-1:0]   n_cnt_r, n_cnt_nxt, p_cnt_r, p_cnt_nxt;
  logic [BURST_W-1:0] burst_r, burst_nxt;
  logic               n_empty, p_empty, below_limit;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == LAST_SLOT) ? '0 : ptr + 1'b1;
  endfunction

  assign n_empty     = (n_cnt_r == '0);
  assign p_empty     = (p_cnt_r == '0);
  assign below_limit = (burst_r < burst_limit);

  always_comb begin
    req        = '0;
    req.status = ST_ENQUEUED;
    n_head_nxt = n_head_r;
    n_tail_nxt = n_tail_r;
    p_head_nxt = p_head_r;
    p_tail_nxt = p_tail_r;
    n_cnt_nxt  = n_cnt_r;
    p_cnt_nxt  = p_cnt_r;
    burst_nxt  = burst_r;
    if (accept) begin
      unique case (command)
        CMD_ENQ_NORMAL: begin
          if (n_cnt_r == FULL_CNT) begin
            req.status = ST_DROPPED;
          end else begin
            req.wr_normal = 1'b1;
            n_tail_nxt    = wrap_inc(n_tail_r);
            n_cnt_nxt     = n_cnt_r + 1'b1;
          end
        end
        CMD_ENQ_PRIORITY: begin
          if (p_cnt_r == FULL_CNT) begin
            req.status = ST_DROPPED;
          end else begin
            req.wr_priority = 1'b1;
            p_tail_nxt      = wrap_inc(p_tail_r);
            p_cnt_nxt       = p_cnt_r + 1'b1;
          end
        end
        default: begin
          // serve; the unused code with bit 1 set acts the same
          if (n_empty && p_empty) begin
            req.status = ST_WAIT;
          end else if ((below_limit && !p_empty) || n_empty) begin
            req.rd_priority = 1'b1;
            req.status      = ST_SERVED_PRIORITY;
            p_head_nxt      = wrap_inc(p_head_r);
            p_cnt_nxt       = p_cnt_r - 1'b1;
            if (below_limit) begin
              burst_nxt = burst_r + 1'b1;
            end
          end else begin
            req.rd_normal = 1'b1;
            req.status    = ST_SERVED_NORMAL;
            n_head_nxt    = wrap_inc(n_head_r);
            n_cnt_nxt     = n_cnt_r - 1'b1;
            burst_nxt     = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_head_r <= '0;
      n_tail_r <= '0;
      p_head_r <= '0;
      p_tail_r <= '0;
      n_cnt_r  <= '0;
      p_cnt_r  <= '0;
      burst_r  <= '0;
    end else begin
      n_head_r <= n_head_nxt;
      n_tail_r <= n_tail_nxt;
      p_head_r <= p_head_nxt;
      p_tail_r <= p_tail_nxt;
      n_cnt_r  <= n_cnt_nxt;
      p_cnt_r  <= p_cnt_nxt;
      burst_r  <= burst_nxt;
    end
  end

  assign n_head = n_head_r;
  assign n_tail = n_tail_r;
  assign p_head = p_head_r;
  assign p_tail = p_tail_r;

  `TCQA_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, (n_cnt_r <= FULL_CNT) && (p_cnt_r <= FULL_CNT), "queue count past depth")
  `TCQA_ASSERT_ALWAYS(a_one_read, clk, rst_n, !(req.rd_normal && req.rd_priority), "both queues popped")
  `TCQA_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, req.rd_normal || req.rd_priority, (req.rd_normal && !n_empty) || (req.rd_priority && !p_empty), "pop from empty queue")
  `TCQA_ASSERT_NEXT(a_burst_clear, clk, rst_n, req.rd_normal, burst_r == '0, "burst count not cleared")

endmodule

// ===== design/two_class_queue_burst_limited_arbiter.sv =====
`timescale 1ns / 1ps
// Two-queue arbiter (normal and priority classes, QUEUE_DEPTH words each, held in two
// single-port-write, registered-read memories). A request is taken on every cycle that
// start is high; busy stays low, so one request per cycle is sustained. Each request gives
// exactly one result, shown on out_status / out_served_word with out_valid high for one
// cycle, in the cycle after the request: that cycle is the registered read of the queue
// memory on a serve. The receiver cannot stall, so results must be taken as they come.
// cfg_ready is always high; a write of cfg_data sets the priority burst limit used by
// the following requests.
module two_class_queue_burst_limited_arbiter
  import tcqa_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ITEM_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [WORD_W-1:0]   in_item_word,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [WORD_W-1:0]   out_served_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BURST_W-1:0]  cfg_data
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  tcqa_req_t           req;
  logic [PTR_W-1:0]    n_head, n_tail, p_head, p_tail;
  logic [63:0]         in_word64, n_rd64, p_rd64;
  logic [ITEM_WIDTH-1:0] wr_word, n_rd_data, p_rd_data;
  logic                accept;
  logic [BURST_W-1:0]  limit_r;
  logic                out_valid_r, sel_n_r, sel_p_r;
  logic [STATUS_W-1:0] status_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign in_word64 = {32'b0, in_item_word};
  assign wr_word   = in_word64[ITEM_WIDTH-1:0];

  tcqa_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .burst_limit(limit_r),
    .req        (req),
    .n_head     (n_head),
    .n_tail     (n_tail),
    .p_head     (p_head),
    .p_tail     (p_tail)
  );

  tcqa_store #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(ITEM_WIDTH)
  ) u_normal_store (
    .clk    (clk),
    .wr_en  (req.wr_normal),
    .wr_addr(n_tail),
    .wr_data(wr_word),
    .rd_en  (req.rd_normal),
    .rd_addr(n_head),
    .rd_data(n_rd_data)
  );

  tcqa_store #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(ITEM_WIDTH)
  ) u_priority_store (
    .clk    (clk),
    .wr_en  (req.wr_priority),
    .wr_addr(p_tail),
    .wr_data(wr_word),
    .rd_en  (req.rd_priority),
    .rd_addr(p_head),
    .rd_data(p_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= BURST_LIMIT_RESET;
      out_valid_r <= 1'b0;
      sel_n_r     <= 1'b0;
      sel_p_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      out_valid_r <= accept;
      sel_n_r     <= req.rd_normal;
      sel_p_r     <= req.rd_priority;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= req.status;
  end

  assign n_rd64 = 64'(n_rd_data);
  assign p_rd64 = 64'(p_rd_data);

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_served_word = sel_p_r ? p_rd64[WORD_W-1:0] :
                           sel_n_r ? n_rd64[WORD_W-1:0] : '0;

endmodule
